[rtl/rlfs_pkg.sv]
`default_nettype none

package rlfs_pkg;

   localparam int DEFAULT_MAX_LEDS = 32;

   localparam int LED_COUNT_W = 6;
   localparam int LED_IDX_W   = 5;
   localparam int COLOUR_W    = 24;
   localparam int HEADER_W    = 8;
   localparam int WORD_W      = 32;

   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 6'd1;

   localparam logic [HEADER_W-1:0] HDR_MARK   = 8'hE0;
   localparam logic [WORD_W-1:0]   START_WORD = 32'h0000_0000;
   localparam logic [WORD_W-1:0]   END_WORD   = 32'hFFFF_FFFF;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = 1;
   localparam int Q_CNT_W     = 2;

   typedef enum logic [1:0] {
      OP_SET_COLOUR = 2'd0,
      OP_SET_BRIGHT = 2'd1,
      OP_SET_ALL    = 2'd2,
      OP_REFRESH    = 2'd3
   } op_type;

   // classified command as carried by the queue
   typedef struct packed {
      op_type                 op;
      logic [LED_IDX_W-1:0]   led_index;
      logic [COLOUR_W-1:0]    colour;    // {blue, green, red}
      logic [HEADER_W-1:0]    header;    // HDR_MARK | brightness
   } cmd_type;

endpackage

`default_nettype wire

[rtl/rlfs_front.sv]
`default_nettype none

module rlfs_front #(
   parameter int MAX_LEDS = rlfs_pkg::DEFAULT_MAX_LEDS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [rlfs_pkg::LED_IDX_W-1:0]     req_led_index,
   input  wire logic [7:0]                         req_red,
   input  wire logic [7:0]                         req_green,
   input  wire logic [7:0]                         req_blue,
   input  wire logic [7:0]                         req_brightness,
   input  wire logic [$clog2(MAX_LEDS+1)-1:0]      count_eff,
   input  wire logic                               q_full,
   output      logic                               push,
   output      rlfs_pkg::cmd_type                  push_data
);
   import rlfs_pkg::*;

   logic    stage_vld_ff, stage_vld_in;
   cmd_type stage_ff, stage_in;
   cmd_type cmd_new;
   logic    accept;
   logic    in_range;
   logic    keep;

   assign busy      = stage_vld_ff && q_full;
   assign accept    = start && !busy;
   assign push      = stage_vld_ff && !q_full;
   assign push_data = stage_ff;

   assign in_range = 7'(req_led_index) < 7'(count_eff);

   always_comb begin
      cmd_new.op        = op_type'(req_opcode);
      cmd_new.led_index = req_led_index;
      cmd_new.colour    = {req_blue, req_green, req_red};
      cmd_new.header    = HDR_MARK | req_brightness;
   end

   // single sets that miss the strip are dropped here
   always_comb begin
      unique case (cmd_new.op)
         OP_SET_COLOUR, OP_SET_BRIGHT: keep = in_range;
         default:                      keep = 1'b1;
      endcase
   end

   always_comb begin
      stage_vld_in = stage_vld_ff && q_full;
      stage_in     = stage_ff;
      if (accept && keep) begin
         stage_vld_in = 1'b1;
         stage_in     = cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

[rtl/rlfs_queue.sv]
`default_nettype none

module rlfs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rlfs_pkg::cmd_type push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              pop_valid,
   output      rlfs_pkg::cmd_type pop_data
);
   import rlfs_pkg::*;

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_pop;

   assign full      = count_ff == Q_CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !push |=> count_ff == $past(count_ff) - Q_CNT_W'(1))
      else $error("queue pop lost");
`endif

endmodule

`default_nettype wire

[rtl/rlfs_back.sv]
`default_nettype none

module rlfs_back #(
   parameter int MAX_LEDS = rlfs_pkg::DEFAULT_MAX_LEDS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [$clog2(MAX_LEDS+1)-1:0]  count_eff,
   input  wire logic                           q_valid,
   input  wire rlfs_pkg::cmd_type              q_data,
   output      logic                           pop,
   output      logic                           rsp_valid,
   output      logic [rlfs_pkg::WORD_W-1:0]    rsp_frame_word,
   output      logic                           rsp_last_word
);
   import rlfs_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEDS + 1);
   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SWEEP,
      B_FETCH,
      B_END
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      cnt_next;
   logic                  cnt_last;
   cmd_type               cur_ff, cur_in;

   logic                  rd_pend_ff, rd_pend_in;
   logic [COLOUR_W-1:0]   rd_col_ff;
   logic [HEADER_W-1:0]   rd_hdr_ff;
   logic                  rd_col_vld_ff;
   logic                  rd_hdr_vld_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;

   logic [COLOUR_W-1:0]   col_mem_ff [MAX_LEDS];
   logic [HEADER_W-1:0]   hdr_mem_ff [MAX_LEDS];
   logic [MAX_LEDS-1:0]   col_vld_ff, col_vld_in;
   logic [MAX_LEDS-1:0]   hdr_vld_ff, hdr_vld_in;

   logic                  col_we;
   logic                  hdr_we;
   logic [IDX_W-1:0]      wr_addr;
   logic [COLOUR_W-1:0]   wr_col;
   logic [HEADER_W-1:0]   wr_hdr;
   logic [COLOUR_W-1:0]   led_col;
   logic [HEADER_W-1:0]   led_hdr;

   assign cnt_next = CNT_W'(cnt_ff) + CNT_W'(1);
   assign cnt_last = cnt_next == count_eff;

   // entries never written read as zero
   assign led_col = rd_col_vld_ff ? rd_col_ff : '0;
   assign led_hdr = rd_hdr_vld_ff ? rd_hdr_ff : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      pop          = 1'b0;
      rd_pend_in   = state_ff == B_FETCH;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_word_in  = rsp_word_ff;
      col_we       = 1'b0;
      hdr_we       = 1'b0;
      wr_addr      = cnt_ff;
      wr_col       = cur_ff.colour;
      wr_hdr       = cur_ff.header;

      // an LED word read in the previous cycle goes out now
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = {led_hdr, led_col[23:16], led_col[15:8], led_col[7:0]};
      end

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cur_in = q_data;
               wr_col = q_data.colour;
               wr_hdr = q_data.header;
               unique case (q_data.op)
                  OP_SET_COLOUR: begin
                     col_we  = 1'b1;
                     wr_addr = IDX_W'(q_data.led_index);
                  end
                  OP_SET_BRIGHT: begin
                     hdr_we  = 1'b1;
                     wr_addr = IDX_W'(q_data.led_index);
                  end
                  OP_SET_ALL: begin
                     cnt_in = '0;
                     if (count_eff != '0) begin
                        state_in = B_SWEEP;
                     end
                  end
                  OP_REFRESH: begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = START_WORD;
                     cnt_in       = '0;
                     state_in     = (count_eff != '0) ? B_FETCH : B_END;
                  end
                  default: ;
               endcase
            end
         end
         B_SWEEP: begin
            col_we = 1'b1;
            hdr_we = 1'b1;
            cnt_in = IDX_W'(cnt_next);
            if (cnt_last) begin
               state_in = B_IDLE;
            end
         end
         B_FETCH: begin
            cnt_in = IDX_W'(cnt_next);
            if (cnt_last) begin
               state_in = B_END;
            end
         end
         B_END: begin
            // wait for the last LED word to drain
            if (!rd_pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_word_in  = END_WORD;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      col_vld_in = col_vld_ff;
      hdr_vld_in = hdr_vld_ff;
      if (col_we) begin
         col_vld_in[wr_addr] = 1'b1;
      end
      if (hdr_we) begin
         hdr_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         col_vld_ff   <= '0;
         hdr_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         col_vld_ff   <= col_vld_in;
         hdr_vld_ff   <= hdr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
   end

   // LED store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem_ff[wr_addr] <= wr_col;
      end
      if (hdr_we) begin
         hdr_mem_ff[wr_addr] <= wr_hdr;
      end
      if (state_ff == B_FETCH) begin
         rd_col_ff     <= col_mem_ff[cnt_ff];
         rd_hdr_ff     <= hdr_mem_ff[cnt_ff];
         rd_col_vld_ff <= col_vld_ff[cnt_ff];
         rd_hdr_vld_ff <= hdr_vld_ff[cnt_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_word = rsp_word_ff;
   assign rsp_last_word  = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_valid_ff && rsp_word_ff == END_WORD)
      else $error("last word is not the end word");
   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> state_ff == B_IDLE)
      else $error("back end still busy on the end word");
   a_read_in_refresh: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == B_FETCH || state_ff == B_END)
      else $error("store read outside a refresh");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != B_IDLE |-> !col_we || state_ff == B_SWEEP)
      else $error("single write while back end busy");
`endif

endmodule

`default_nettype wire

[rtl/rgb_led_strip_frame_serializer.sv]
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------------
// req       start / busy              req_opcode, req_led_index, req_red,
//                                     req_green, req_blue, req_brightness
// rsp       rsp_valid (1-cycle strobe) rsp_frame_word, rsp_last_word
// csr       csr_valid / csr_ready     csr_led_count
//
// Items pass a one-entry front stage and a two-entry queue before the back end runs them.
// Back end: set colour / set brightness is a single store write at pop, set all pops and then
// makes one store write per cycle, refresh sends n+2 words (start, n LED words, end); n is
// led_count capped at MAX_LEDS.
// busy rises only while the front stage holds an item and the queue is full; the receiver
// cannot stall, each word is a one-cycle strobe.
// Synchronous reset: led_count returns to 1; per-entry valid bits clear, so the store
// reads as zero at once.

module rgb_led_strip_frame_serializer #(
   parameter int MAX_LEDS = rlfs_pkg::DEFAULT_MAX_LEDS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [rlfs_pkg::LED_IDX_W-1:0]   req_led_index,
   input  wire logic [7:0]                       req_red,
   input  wire logic [7:0]                       req_green,
   input  wire logic [7:0]                       req_blue,
   input  wire logic [7:0]                       req_brightness,
   output      logic                             rsp_valid,
   output      logic [rlfs_pkg::WORD_W-1:0]      rsp_frame_word,
   output      logic                             rsp_last_word,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [rlfs_pkg::LED_COUNT_W-1:0] csr_led_count
);
   import rlfs_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEDS + 1);

   logic [LED_COUNT_W-1:0] led_count_ff, led_count_in;
   logic [CNT_W-1:0]       count_eff;
   logic                   q_full;
   logic                   q_push;
   cmd_type                q_push_data;
   logic                   q_pop;
   logic                   q_valid;
   cmd_type                q_data;

   assign csr_ready = 1'b1;

   always_comb begin
      led_count_in = (csr_valid && csr_ready) ? csr_led_count : led_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= LED_COUNT_RESET;
      end else begin
         led_count_ff <= led_count_in;
      end
   end

   assign count_eff = (7'(led_count_ff) > 7'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                       : CNT_W'(led_count_ff);

   rlfs_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_led_index  (req_led_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_brightness (req_brightness),
      .count_eff      (count_eff),
      .q_full         (q_full),
      .push           (q_push),
      .push_data      (q_push_data)
   );

   rlfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   rlfs_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .count_eff      (count_eff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_frame_word (rsp_frame_word),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

`default_nettype wire

[tb/rgb_led_strip_frame_serializer_tb.sv]
module rgb_led_strip_frame_serializer_tb;
   import rlfs_pkg::*;

   localparam int CAP        = DEFAULT_MAX_LEDS;
   // front stage, two queue slots and back end, each able to hold a full-strip set all
   localparam int DRAIN      = 4 * (CAP + 3) + 8;
   localparam int QUIET_MAX  = 2000;
   localparam int GAP_PCT    = 31;
   localparam int SHOW_MAX   = 10;

   typedef struct {
      op_type                 op;
      logic [LED_IDX_W-1:0]   idx;
      logic [7:0]             red;
      logic [7:0]             green;
      logic [7:0]             blue;
      logic [7:0]             bright;
   } led_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } frame_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_opcode = '0;
   logic [LED_IDX_W-1:0]   req_led_index = '0;
   logic [7:0]             req_red = '0;
   logic [7:0]             req_green = '0;
   logic [7:0]             req_blue = '0;
   logic [7:0]             req_brightness = '0;
   logic                   rsp_valid;
   logic [WORD_W-1:0]      rsp_frame_word;
   logic                   rsp_last_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LED_COUNT_W-1:0] csr_led_count = '0;

   rgb_led_strip_frame_serializer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_led_index  (req_led_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_frame_word (rsp_frame_word),
      .rsp_last_word  (rsp_last_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_led_count  (csr_led_count)
   );

   always #1 clock = ~clock;

   // strip model
   logic [COLOUR_W-1:0] colour_mem [CAP];
   logic [HEADER_W-1:0] header_mem [CAP];
   int                  led_count_m = LED_COUNT_RESET;

   led_cmd_type    cmds_waiting [$];
   frame_beat_type words_due [$];
   led_cmd_type    cmd_on_bus;
   int             cmds_issued = 0;
   int             cmds_taken = 0;
   bit             no_gaps = 1'b0;
   int             mismatches = 0;
   int             quiet_cycles = 0;

   initial begin
      for (int i = 0; i < CAP; i++) begin
         colour_mem[i] = '0;
         header_mem[i] = '0;
      end
   end

   task automatic strip_predict(input led_cmd_type c);
      int                  n;
      logic [HEADER_W-1:0] hdr;
      n = (led_count_m > CAP) ? CAP : led_count_m;
      hdr = HDR_MARK | c.bright;
      case (c.op)
         OP_SET_COLOUR: begin
            if (int'(c.idx) < n) colour_mem[c.idx] = {c.blue, c.green, c.red};
         end
         OP_SET_BRIGHT: begin
            if (int'(c.idx) < n) header_mem[c.idx] = hdr;
         end
         OP_SET_ALL: begin
            for (int i = 0; i < n; i++) begin
               colour_mem[i] = {c.blue, c.green, c.red};
               header_mem[i] = hdr;
            end
         end
         default: begin
            words_due.push_back('{START_WORD, 1'b0});
            for (int i = 0; i < n; i++)
               words_due.push_back('{{header_mem[i], colour_mem[i]}, 1'b0});
            words_due.push_back('{END_WORD, 1'b1});
         end
      endcase
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (cmds_issued == cmds_taken) begin
         if (cmds_waiting.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
            led_cmd_type c;
            c = cmds_waiting.pop_front();
            cmd_on_bus     = c;
            cmds_issued    = cmds_issued + 1;
            start          <= 1'b1;
            req_opcode     <= c.op;
            req_led_index  <= c.idx;
            req_red        <= c.red;
            req_green      <= c.green;
            req_blue       <= c.blue;
            req_brightness <= c.bright;
         end else begin
            start          <= 1'b0;
            req_opcode     <= 2'($urandom);
            req_led_index  <= LED_IDX_W'($urandom);
            req_red        <= 8'($urandom);
            req_green      <= 8'($urandom);
            req_blue       <= 8'($urandom);
            req_brightness <= 8'($urandom);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         strip_predict(cmd_on_bus);
         cmds_taken = cmds_taken + 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
               $display("unexpected word %h last %b", rsp_frame_word, rsp_last_word);
         end else begin
            frame_beat_type w;
            w = words_due.pop_front();
            if (rsp_frame_word !== w.word || rsp_last_word !== w.last) begin
               mismatches++;
               if (mismatches <= SHOW_MAX)
                  $display("word mismatch: expected %h last %b, got %h last %b",
                           w.word, w.last, rsp_frame_word, rsp_last_word);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_MAX) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic led_cmd_type mk_cmd(op_type op, int idx, int r, int g, int b, int br);
      led_cmd_type c;
      c.op     = op;
      c.idx    = LED_IDX_W'(idx);
      c.red    = 8'(r);
      c.green  = 8'(g);
      c.blue   = 8'(b);
      c.bright = 8'(br);
      return c;
   endfunction

   function automatic led_cmd_type rand_cmd();
      led_cmd_type c;
      int          n;
      int          pick;
      n = (led_count_m > CAP) ? CAP : led_count_m;
      pick = $urandom_range(99);
      if (pick < 35)      c.op = OP_SET_COLOUR;
      else if (pick < 60) c.op = OP_SET_BRIGHT;
      else if (pick < 75) c.op = OP_SET_ALL;
      else                c.op = OP_REFRESH;
      // mostly in-range addresses, some random ones that may fall outside the strip
      if (n > 0 && $urandom_range(99) < 85) c.idx = LED_IDX_W'($urandom_range(n - 1));
      else                                  c.idx = LED_IDX_W'($urandom);
      c.red    = 8'($urandom);
      c.green  = 8'($urandom);
      c.blue   = 8'($urandom);
      c.bright = 8'($urandom);
      return c;
   endfunction

   // block idle: nothing queued, nothing on the bus, nothing outstanding
   task automatic wait_idle();
      while (cmds_waiting.size() != 0 || cmds_issued != cmds_taken || words_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_led_count(input int v);
      wait_idle();
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_led_count <= LED_COUNT_W'(v);
      do @(posedge clock); while (!csr_ready);
      led_count_m = v;
      @(negedge clock);
      csr_valid     <= 1'b0;
      csr_led_count <= LED_COUNT_W'($urandom);
   endtask

   int phase_counts [8];

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset count of one, store cleared: header reads zero
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 0, 'hFF, 'hFF, 'hFF, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 1, 'h12, 'h34, 'h56, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_BRIGHT, 0, 0, 0, 0, 'h00));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_BRIGHT, 0, 0, 0, 0, 'hFF));
      cmds_waiting.push_back(mk_cmd(OP_SET_BRIGHT, 31, 0, 0, 0, 'h1F));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));

      // full strip
      write_led_count(CAP);
      cmds_waiting.push_back(mk_cmd(OP_SET_ALL,    0, 0, 0, 0, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 31, 'hFF, 'h00, 'hFF, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_BRIGHT, 31, 0, 0, 0, 'hFF));
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 0, 'h00, 'hFF, 'h00, 0));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_ALL,    17, 'hAA, 'h55, 'hFF, 'h0A));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));

      // zero count: set all and writes do nothing, refresh is two words
      write_led_count(0);
      cmds_waiting.push_back(mk_cmd(OP_SET_ALL,    0, 1, 2, 3, 4));
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 0, 9, 9, 9, 0));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));

      // count above capacity saturates
      write_led_count(63);
      cmds_waiting.push_back(mk_cmd(OP_SET_COLOUR, 31, 'h01, 'h02, 'h03, 0));
      cmds_waiting.push_back(mk_cmd(OP_SET_BRIGHT, 30, 0, 0, 0, 'h15));
      cmds_waiting.push_back(mk_cmd(OP_REFRESH,    0, 0, 0, 0, 0));

      phase_counts = '{7, 32, 1, 63, 0, 20, 45, $urandom_range(1, 63)};
      foreach (phase_counts[p]) begin
         write_led_count(phase_counts[p]);
         no_gaps = (p == 3);
         for (int k = 0; k < 14; k++) begin
            cmds_waiting.push_back(rand_cmd());
            // sender holds off until the strip has drained
            if (p == 1 && k == 7) wait_idle();
         end
      end

      wait_idle();
      no_gaps = 1'b0;
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && words_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
